// ===== rtl/core/cutoff_top3_neighbour_vote_core_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef CUTOFF_TOP3_NEIGHBOUR_VOTE_CORE_DEFINES_SVH
`define CUTOFF_TOP3_NEIGHBOUR_VOTE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CTNV_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CTNV_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ctnv_pkg.sv =====
`timescale 1ns / 1ps
package ctnv_pkg;

    // Scores are signed Q16.16; only ordering compares are done on them.
    localparam int SCORE_W        = 32;
    localparam int IDX_W          = 16;
    localparam int CLASS_ID_WIDTH = 16;
    localparam int KEEP_DEPTH     = 3;
    localparam int KEEP_CNT_W     = $clog2(KEEP_DEPTH + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SCORE_W-1:0] CUTOFF_RESET = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        PICK_BEST   = 2'd0,
        PICK_SECOND = 2'd1
    } pick_t;

    typedef struct packed {
        logic [IDX_W-1:0]          query_index;
        logic [IDX_W-1:0]          neighbour_index;
        logic signed [SCORE_W-1:0] distance_score;
        logic [CLASS_ID_WIDTH-1:0] neighbour_class;
        logic                      last_candidate;
    } cand_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]          result_query;
        logic                      assigned;
        logic [CLASS_ID_WIDTH-1:0] chosen_class;
        logic signed [SCORE_W-1:0] chosen_score;
        logic [IDX_W-1:0]          chosen_neighbour;
    } vote_out_t;

    // Classified candidate as it sits in the queue.
    typedef struct packed {
        cand_in_t cand;
        logic     keep;
    } q_item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [CLASS_ID_WIDTH-1:0] cls;
        logic [IDX_W-1:0]          nb;
    } kept_t;

endpackage

// ===== rtl/core/ctnv_front.sv =====
`timescale 1ns / 1ps
module ctnv_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ctnv_pkg::cand_in_t       s_data,
    input  logic                     cfg_wr_en,
    input  logic [31:0]              cfg_wr_data,
    input  ctnv_pkg::q_status_t      q_status,
    output logic                     push,
    output ctnv_pkg::q_item_t        push_item
);
    import ctnv_pkg::*;

    logic [SCORE_W-1:0] cutoff_reg;
    logic [SCORE_W-1:0] cutoff_next;

    always_comb begin
        cutoff_next = cutoff_reg;
        if (cfg_wr_en) begin
            cutoff_next = cfg_wr_data[SCORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
        end else begin
            cutoff_reg <= cutoff_next;
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    // Qualify: score at or below cutoff, class known.
    always_comb begin
        push_item.cand = s_data;
        push_item.keep = ($signed(s_data.distance_score) <= $signed(cutoff_reg)) &&
                         (s_data.neighbour_class != '0);
    end

endmodule

// ===== rtl/core/ctnv_queue.sv =====
`timescale 1ns / 1ps
module ctnv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ctnv_pkg::q_item_t   push_item,
    input  logic                pop,
    output ctnv_pkg::q_item_t   head,
    output ctnv_pkg::q_status_t status
);
    import ctnv_pkg::*;

    q_item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head             = slot_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

// ===== rtl/core/ctnv_back.sv =====
`timescale 1ns / 1ps
module ctnv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctnv_pkg::q_item_t   head,
    input  ctnv_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ctnv_pkg::vote_out_t m_data
);
    import ctnv_pkg::*;

    kept_t                 kept_reg [KEEP_DEPTH];
    kept_t                 kept_next [KEEP_DEPTH];
    logic [KEEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    vote_out_t             m_data_reg, m_data_next;

    logic [KEEP_DEPTH-1:0] ge;
    logic [KEEP_CNT_W-1:0] pos;
    logic [KEEP_CNT_W-1:0] cnt_ins;
    logic                  ins;
    kept_t                 cand_k;
    pick_t                 pick;
    vote_out_t             vote;

    // Parallel sorted insert: pos counts kept entries scoring <= candidate,
    // so equal scores keep the earlier arrival ahead.
    always_comb begin
        cand_k.score = head.cand.distance_score;
        cand_k.cls   = head.cand.neighbour_class;
        cand_k.nb    = head.cand.neighbour_index;
        pos = '0;
        for (int i = 0; i < KEEP_DEPTH; i++) begin
            ge[i] = (KEEP_CNT_W'(i) < cnt_reg) &&
                    ($signed(kept_reg[i].score) <= $signed(cand_k.score));
            pos   = pos + KEEP_CNT_W'(ge[i]);
        end
        ins = head.keep && (pos < KEEP_CNT_W'(KEEP_DEPTH));
        for (int i = 0; i < KEEP_DEPTH; i++) begin
            if (!ins || (KEEP_CNT_W'(i) < pos)) begin
                kept_next[i] = kept_reg[i];
            end else if (KEEP_CNT_W'(i) == pos) begin
                kept_next[i] = cand_k;
            end else if (i > 0) begin
                kept_next[i] = kept_reg[i-1];
            end else begin
                kept_next[i] = kept_reg[i];
            end
        end
        cnt_ins = (ins && (cnt_reg < KEEP_CNT_W'(KEEP_DEPTH))) ? cnt_reg + 1'b1 : cnt_reg;
    end

    // Vote over the list as it stands after this item.
    always_comb begin
        pick = PICK_BEST;
        if (cnt_ins == KEEP_CNT_W'(KEEP_DEPTH)) begin
            if ((kept_next[0].cls == kept_next[1].cls) ||
                (kept_next[0].cls == kept_next[2].cls)) begin
                pick = PICK_BEST;
            end else if (kept_next[1].cls == kept_next[2].cls) begin
                pick = PICK_SECOND;
            end else begin
                pick = PICK_BEST;
            end
        end
        vote.result_query = head.cand.query_index;
        if (cnt_ins == '0) begin
            vote.assigned         = 1'b0;
            vote.chosen_class     = '0;
            vote.chosen_score     = '0;
            vote.chosen_neighbour = '0;
        end else begin
            vote.assigned = 1'b1;
            case (pick)
                PICK_SECOND: begin
                    vote.chosen_class     = kept_next[1].cls;
                    vote.chosen_score     = kept_next[1].score;
                    vote.chosen_neighbour = kept_next[1].nb;
                end
                default: begin
                    vote.chosen_class     = kept_next[0].cls;
                    vote.chosen_score     = kept_next[0].score;
                    vote.chosen_neighbour = kept_next[0].nb;
                end
            endcase
        end
    end

    // A last item waits only while the result register is still occupied.
    assign pop = q_status.not_empty &&
                 (!head.cand.last_candidate || !m_valid_reg || m_ready);

    always_comb begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            cnt_next = head.cand.last_candidate ? '0 : cnt_ins;
            if (head.cand.last_candidate) begin
                m_valid_next = 1'b1;
                m_data_next  = vote;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (pop) begin
            for (int i = 0; i < KEEP_DEPTH; i++) begin
                kept_reg[i] <= kept_next[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/cutoff_top3_neighbour_vote_core.sv =====
`timescale 1ns / 1ps
// Top-three neighbour vote (k = 3). Candidates of one query stream in one
// transfer per cycle; a candidate is kept if its signed Q16.16 score is at
// or below score_cutoff and its class is nonzero, and the three smallest
// kept scores are held in order (ties keep the earlier candidate). The
// transfer flagged last_candidate produces exactly one result transfer
// carrying the vote and clears the list; other transfers produce none.
// Sustained rate is one candidate per cycle while no last candidate waits
// on an unaccepted result, set by the combinational three-entry sorted
// insert in the back end. A last candidate taken from the queue is voted
// into the result register, which drives m_valid, once that register is
// free. A last candidate waits in the queue while an earlier result is
// still unaccepted; the two-entry queue then fills and s_ready drops.
// score_cutoff is written through cfg_wr_en/cfg_wr_data and must only
// change while the core is idle.
module cutoff_top3_neighbour_vote_core (
    input  logic                aclk,
    input  logic                aresetn,
    // candidate input
    input  logic                s_valid,
    output logic                s_ready,
    input  ctnv_pkg::cand_in_t  s_data,
    // vote result
    output logic                m_valid,
    input  logic                m_ready,
    output ctnv_pkg::vote_out_t m_data,
    // score_cutoff register write
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);
    import ctnv_pkg::*;

    // front -> queue
    logic      push;
    q_item_t   push_item;
    // queue -> back
    logic      pop;
    q_item_t   head;
    q_status_t q_status;

    // Front end: holds the cutoff, qualifies each candidate on accept.
    ctnv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    // Two-entry queue decouples input stalls from result back-pressure.
    ctnv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Back end: sorted insert, vote on last, registered result.
    ctnv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== rtl/core/ctnv_checker.sv =====
`timescale 1ns / 1ps
`include "cutoff_top3_neighbour_vote_core_defines.svh"
module ctnv_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ctnv_pkg::vote_out_t m_data
);
    import ctnv_pkg::*;

    // A pending result holds until its transfer.
    `CTNV_ASSERT_NEXT(a_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // No class chosen: all chosen fields read zero.
    `CTNV_ASSERT_NOW(a_none_zero, aclk, !aresetn, m_valid && !m_data.assigned, (m_data.chosen_class == '0) && (m_data.chosen_score == '0) && (m_data.chosen_neighbour == '0), "unassigned result not zeroed")

    // A chosen class is never the unknown class.
    `CTNV_ASSERT_NOW(a_known_class, aclk, !aresetn, m_valid && m_data.assigned, m_data.chosen_class != '0, "unknown class chosen")

    // Reset leaves no result pending and the input open.
    `CTNV_ASSERT_NEXT(a_reset, aclk, 1'b0, !aresetn, !m_valid && s_ready, "bad state after reset")

endmodule

bind cutoff_top3_neighbour_vote_core ctnv_checker u_ctnv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ctnv_pkg::*;

    // Stall bounds: sender gaps are bounded in send_cand, the receiver pattern
    // forces ready at least once each segment, and the core votes once a last
    // candidate leaves its queue. The watchdog limit sits well above these
    // bounds.
    localparam int WATCHDOG_LIMIT = 1000;
    // Non-last candidates leave no result behind, so give the core time to drain
    // its queue, plus margin, before touching the cutoff.
    localparam int CFG_HOLDOFF    = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 110;
    localparam int REPORT_MAX     = 10;

    // Keeps the three best qualifying candidates of the open query and
    // queues the vote expected for every last candidate.
    class vote_scoreboard;
        logic signed [SCORE_W-1:0] cutoff;
        kept_t                     kept[KEEP_DEPTH];
        int                        n_kept;
        vote_out_t                 expected_votes[$];
        int unsigned               mismatches;

        function new();
            cutoff     = CUTOFF_RESET;
            mismatches = 0;
            clear_list();
        endfunction

        function void clear_list();
            for (int i = 0; i < KEEP_DEPTH; i++)
                kept[i] = '{score: '1, cls: '0, nb: '0};
            n_kept = 0;
        endfunction

        function void set_cutoff(input logic [SCORE_W-1:0] value);
            cutoff = value;
        endfunction

        function int pending();
            return expected_votes.size();
        endfunction

        function void note_candidate(input cand_in_t c);
            int        pos;
            int        k;
            pick_t     pick;
            vote_out_t vote;
            if ($signed(c.distance_score) <= $signed(cutoff) && c.neighbour_class != '0) begin
                // Ties go behind the entries already held.
                pos = 0;
                while (pos < n_kept && $signed(kept[pos].score) <= $signed(c.distance_score))
                    pos++;
                if (pos < KEEP_DEPTH) begin
                    k = (n_kept < KEEP_DEPTH) ? n_kept : KEEP_DEPTH - 1;
                    while (k > pos) begin
                        kept[k] = kept[k-1];
                        k--;
                    end
                    kept[pos] = '{score: c.distance_score, cls: c.neighbour_class,
                                  nb: c.neighbour_index};
                    if (n_kept < KEEP_DEPTH)
                        n_kept++;
                end
            end
            if (!c.last_candidate)
                return;
            // Second place wins only when it pairs with third and best pairs with neither.
            pick = PICK_BEST;
            if (n_kept == KEEP_DEPTH && kept[0].cls != kept[1].cls &&
                kept[0].cls != kept[2].cls && kept[1].cls == kept[2].cls)
                pick = PICK_SECOND;
            vote = '0;
            vote.result_query = c.query_index;
            if (n_kept != 0) begin
                vote.assigned         = 1'b1;
                vote.chosen_class     = kept[int'(pick)].cls;
                vote.chosen_score     = kept[int'(pick)].score;
                vote.chosen_neighbour = kept[int'(pick)].nb;
            end
            expected_votes.push_back(vote);
            clear_list();
        endfunction

        function void check_vote(input vote_out_t got);
            vote_out_t want;
            if (expected_votes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected vote: q=%h asg=%b cls=%h score=%h nb=%h",
                             got.result_query, got.assigned, got.chosen_class,
                             got.chosen_score, got.chosen_neighbour);
                return;
            end
            want = expected_votes.pop_front();
            if (got.result_query !== want.result_query || got.assigned !== want.assigned ||
                got.chosen_class !== want.chosen_class ||
                got.chosen_score !== want.chosen_score ||
                got.chosen_neighbour !== want.chosen_neighbour) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("vote mismatch: want q=%h asg=%b cls=%h score=%h nb=%h, got q=%h asg=%b cls=%h score=%h nb=%h",
                             want.result_query, want.assigned, want.chosen_class,
                             want.chosen_score, want.chosen_neighbour,
                             got.result_query, got.assigned, got.chosen_class,
                             got.chosen_score, got.chosen_neighbour);
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    cand_in_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    vote_out_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    vote_scoreboard votes = new();

    int          burst_left   = 0;
    int          items_sent   = 0;
    int          idle_cycles  = 0;
    logic [31:0] gen_cutoff   = CUTOFF_RESET;
    logic [31:0] stall_pattern = '1;
    logic [4:0]  stall_phase  = '0;

    always #10 aclk = ~aclk;

    cutoff_top3_neighbour_vote_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Receiver: a fresh 32-bit ready pattern each segment; bit 0 is forced
    // high so a stall never outlasts one segment.
    always @(posedge aclk) begin
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = $urandom;
                2:       stall_pattern = $urandom & $urandom;
                default: stall_pattern = $urandom | $urandom;
            endcase
            stall_pattern[0] = 1'b1;
        end
        m_ready <= stall_pattern[stall_phase];
        stall_phase = stall_phase + 1'b1;
    end

    // Monitor: check the result transfer first, then record the candidate
    // transfer of the same edge, so a new expectation lands behind older ones.
    // The watchdog counts edges where neither channel moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                votes.check_vote(m_data);
            if (s_valid && s_ready)
                votes.note_candidate(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    function automatic cand_in_t cand(input logic [15:0] q, input logic [15:0] nb,
                                      input logic [31:0] score, input logic [15:0] cls,
                                      input logic last);
        cand_in_t c;
        c.query_index     = q;
        c.neighbour_index = nb;
        c.distance_score  = score;
        c.neighbour_class = cls;
        c.last_candidate  = last;
        return c;
    endfunction

    // Scores lean toward ties, the cutoff boundary and the extremes.
    function automatic logic [31:0] rand_score();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                v = $urandom_range(0, 6);
                v = (v - 3) * 65536;
            end
            3, 4:    v = gen_cutoff + 32'($urandom_range(0, 4)) - 32'd2;
            5:       v = $urandom_range(0, 3);
            6: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly a few classes so votes agree often; some unknown and wide ids.
    function automatic logic [15:0] rand_class();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'($urandom);
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // One candidate transfer. Within a burst valid stays up and the next
    // item follows in the same step; at burst end valid drops for a gap.
    task automatic send_cand(input cand_in_t c);
        int gap;
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Mostly a well-formed query with random content; sometimes noise with
    // mixed query ids and stray last flags. Always closes on a last item.
    task automatic send_query();
        logic [15:0] q;
        int          n;
        bit          noisy;
        q     = 16'($urandom);
        noisy = ($urandom_range(0, 6) == 0);
        n     = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if (noisy)
                send_cand(cand(16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                               (i == n - 1) || ($urandom_range(0, 3) == 0)));
            else
                send_cand(cand(q, 16'($urandom), rand_score(), rand_class(), i == n - 1));
        end
    endtask

    // Cutoff writes only when the core is idle: all votes in, plus holdoff.
    // The wait samples pending on the clock, so the monitor has noted the latest transfer.
    task automatic write_cutoff(input logic [31:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (votes.pending() != 0);
        repeat (CFG_HOLDOFF) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        votes.set_cutoff(value);
        gen_cutoff = value;
    endtask

    initial begin
        int phase_start;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset cutoff. Only an unknown class: nothing kept.
        send_cand(cand(16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1));
        // Single keeper at the field extremes.
        send_cand(cand(16'hFFFF, 16'hFFFF, 32'h8000_0000, 16'hFFFF, 1'b1));
        // Two kept: best wins.
        send_cand(cand(16'h0001, 16'h0001, 32'h0005_0000, 16'h0002, 1'b0));
        send_cand(cand(16'h0001, 16'h0002, 32'h0003_0000, 16'h0007, 1'b1));
        // Three kept, second and third agree.
        send_cand(cand(16'h0002, 16'h0003, 32'h0001_0000, 16'h0001, 1'b0));
        send_cand(cand(16'h0002, 16'h0004, 32'h0002_0000, 16'h0002, 1'b0));
        send_cand(cand(16'h0002, 16'h0005, 32'h0003_0000, 16'h0002, 1'b1));
        // Three kept, best agrees with third.
        send_cand(cand(16'h0003, 16'h0006, 32'h0000_0001, 16'h0009, 1'b0));
        send_cand(cand(16'h0003, 16'h0007, 32'h0000_0002, 16'h0008, 1'b0));
        send_cand(cand(16'h0003, 16'h0008, 32'h0000_0003, 16'h0009, 1'b1));
        // Equal scores: earlier arrivals hold; full list drops ties and worse.
        send_cand(cand(16'h0004, 16'h0009, 32'h0000_000A, 16'h0004, 1'b0));
        send_cand(cand(16'h0004, 16'h000A, 32'h0000_000A, 16'h0005, 1'b0));
        send_cand(cand(16'h0004, 16'h000B, 32'h0000_000A, 16'h0006, 1'b0));
        send_cand(cand(16'h0004, 16'h000C, 32'h0000_000A, 16'h0007, 1'b0));
        send_cand(cand(16'h0004, 16'h000D, 32'h7FFF_FFFF, 16'h0004, 1'b1));
        // Full list, better candidates push out the tail; the final three classes differ.
        send_cand(cand(16'h0005, 16'h000E, 32'h0000_001E, 16'h0003, 1'b0));
        send_cand(cand(16'h0005, 16'h000F, 32'h0000_0014, 16'h0003, 1'b0));
        send_cand(cand(16'h0005, 16'h0010, 32'h0000_000A, 16'h0005, 1'b0));
        send_cand(cand(16'h0005, 16'h0011, 32'h0000_0005, 16'h0006, 1'b1));
        // Mixed query ids pool; the result takes the last item's id.
        send_cand(cand(16'h0006, 16'h0012, 32'hFFFF_0000, 16'h0001, 1'b0));
        send_cand(cand(16'h0007, 16'h0013, 32'h7FFF_FFFF, 16'h0001, 1'b1));

        // Lowest cutoff: only the most negative score qualifies.
        write_cutoff(32'h8000_0000);
        send_cand(cand(16'h0008, 16'h0014, 32'h8000_0001, 16'h0003, 1'b0));
        send_cand(cand(16'h0008, 16'h0015, 32'h8000_0000, 16'h0004, 1'b1));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       write_cutoff(32'h0000_0000);
                1:       write_cutoff(32'h7FFF_FFFF);
                2:       write_cutoff(32'h8000_0000);
                3:       write_cutoff($urandom);
                default: write_cutoff(32'h0001_8000);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_query();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (votes.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (votes.mismatches == 0 && votes.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ctnv_pkg.sv
rtl/core/ctnv_front.sv
rtl/core/ctnv_queue.sv
rtl/core/ctnv_back.sv
rtl/core/cutoff_top3_neighbour_vote_core.sv
rtl/core/ctnv_checker.sv
tb/testbench.sv
